// ===== rtl/core/mwo_pkg.sv =====
// ----------------------------------------------------------------------------
// mwo_pkg
// Shared types, constants and tables of the wavelet oscillator voice.
// ----------------------------------------------------------------------------
package mwo_pkg;

  localparam int STORE_DEPTH = 4096;
  localparam int STORE_AW    = 12;
  localparam int SIZE_W      = 13;
  localparam int SIZE_MIN    = 128;
  localparam int SINE_AW     = 10;
  localparam int SINE_N      = 1 << SINE_AW;

  typedef enum logic {
    OP_WRITE  = 1'b0,
    OP_SAMPLE = 1'b1
  } op_t;

  typedef enum logic [1:0] {
    CFG_MEM_SIZE     = 2'd0,
    CFG_STEP_PER_HZ  = 2'd1,
    CFG_POINTER_JUMP = 2'd2,
    CFG_START_OFFSET = 2'd3
  } cfg_idx_t;

  typedef struct packed {
    op_t                 op;
    logic [STORE_AW-1:0] address;
    logic [7:0]          data;
    logic [15:0]         sample_index;
    logic [15:0]         macro_mod;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } fetch_t;

  typedef logic [14:0] sine_rom_t [SINE_N];

  localparam logic [13:0] TANH_TAB [34] = '{
    14'd0,     14'd1865,  14'd3674,  14'd5375,  14'd6932,  14'd8319,  14'd9527,
    14'd10559, 14'd11424, 14'd12140, 14'd12724, 14'd13197, 14'd13577, 14'd13880,
    14'd14121, 14'd14311, 14'd14460, 14'd14578, 14'd14670, 14'd14743, 14'd14799,
    14'd14843, 14'd14878, 14'd14905, 14'd14926, 14'd14942, 14'd14955, 14'd14965,
    14'd14973, 14'd14979, 14'd14983, 14'd14987, 14'd14990, 14'd15000
  };

  function automatic logic [14:0] quarter_sine(input int unsigned k);
    longint unsigned u;
    longint unsigned u2;
    longint unsigned t;
    longint unsigned r;
    u  = 64'(k) << (30 - SINE_AW);
    u2 = (u * u) >> 30;
    t  = 64'd5026995 - ((u2 * 64'd172272) >> 30);
    t  = 64'd85569306 - ((u2 * t) >> 30);
    t  = 64'd693598668 - ((u2 * t) >> 30);
    t  = 64'd1686629713 - ((u2 * t) >> 30);
    r  = (((u * t) >> 30) + 64'd16384) >> 15;
    if (r > 64'd32767) r = 64'd32767;
    return 15'(r);
  endfunction

  function automatic sine_rom_t sine_rom_build();
    sine_rom_t rom;
    for (int k = 0; k < SINE_N; k++) rom[k] = quarter_sine(k);
    return rom;
  endfunction

endpackage

// ===== rtl/core/mwo_front.sv =====
// ----------------------------------------------------------------------------
// mwo_front
// Accepts requests, tags them by operation and holds them in a short queue.
// ----------------------------------------------------------------------------
module mwo_front import mwo_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_op,
  input  logic [STORE_AW-1:0] in_address,
  input  logic [7:0]          in_data,
  input  logic [15:0]         in_sample_index,
  input  logic [15:0]         in_macro_mod,
  output fetch_t              fetch,
  input  logic                fetch_pop
);

  cmd_t       q_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] cnt_r;
  logic       push_ok;
  logic       pop_ok;
  cmd_t       cmd_in;

  assign in_full = (cnt_r == 2'd2);
  assign push_ok = in_push && !in_full;
  assign pop_ok  = fetch_pop && (cnt_r != 2'd0);

  always_comb begin
    cmd_in.op           = in_op ? OP_SAMPLE : OP_WRITE;
    cmd_in.address      = in_address;
    cmd_in.data         = in_data;
    cmd_in.sample_index = in_sample_index;
    cmd_in.macro_mod    = in_macro_mod;
  end

  assign fetch.valid = (cnt_r != 2'd0);
  assign fetch.cmd   = q_r[rd_ptr_r];

  always_ff @(posedge clk) begin
    if (push_ok) q_r[wr_ptr_r] <= cmd_in;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      if (push_ok) wr_ptr_r <= ~wr_ptr_r;
      if (pop_ok) rd_ptr_r <= ~rd_ptr_r;
      cnt_r <= cnt_r + 2'(push_ok) - 2'(pop_ok);
    end
  end

endmodule

// ===== rtl/core/mwo_back.sv =====
// ----------------------------------------------------------------------------
// mwo_back
// Sequencer with byte store, sine rom and one shared multiplier.
// ----------------------------------------------------------------------------
module mwo_back import mwo_pkg::*; (
  input  logic               clk,
  input  logic               rst_n,
  input  fetch_t             fetch,
  output logic               fetch_pop,
  input  logic               cfg_valid,
  output logic               cfg_ready,
  input  logic [1:0]         cfg_index,
  input  logic [27:0]        cfg_data,
  output logic               out_empty,
  input  logic               out_pop,
  output logic signed [14:0] out_sample
);

  typedef enum logic [2:0] {
    S_IDLE, S_MOD, S_RD, S_BAND, S_CALC, S_OUT
  } state_t;

  typedef enum logic {
    MOD_INDEX, MOD_POINTER
  } mod_for_t;

  localparam sine_rom_t SINE_ROM = sine_rom_build();

  state_t              state_r;
  mod_for_t            mod_for_r;
  logic [16:0]         mod_r;
  logic [3:0]          mod_j_r;
  logic [SIZE_W-1:0]   mem_size_r;
  logic [27:0]         step_hz_r;
  logic [7:0]          jump_r;
  logic [STORE_AW-1:0] rp_r;
  logic [STORE_AW-1:0] idx_r;
  logic [15:0]         si_r;
  logic [15:0]         mm_r;
  logic [2:0]          rd_cnt_r;
  logic [7:0]          b_r [4];
  logic [7:0]          mem_q_r;
  logic [7:0]          store_mem [STORE_DEPTH];
  logic signed [10:0]  l_r, m_r;
  logic [9:0]          abs_l_r, abs_m_r, abs_h_r;
  logic [4:0]          step_r;
  logic signed [32:0]  mul_a, mul_b;
  logic signed [65:0]  prod_r;
  logic [24:0]         fl_k_r;
  logic [27:0]         fm_k_r;
  logic [28:0]         fh_k_r;
  logic [24:0]         fl_r;
  logic [27:0]         fm_r;
  logic [29:0]         fh_r;
  logic [31:0]         phase_low_r, phase_mid_r, phase_high_r;
  logic [31:0]         pm_r, ph_r;
  logic [16:0]         am_r, ah_r;
  logic [31:0]         cl_r, cm_r, ch_r;
  logic signed [16:0]  sl_r, sm_r, sh_r;
  logic signed [49:0]  acc_r;
  logic signed [23:0]  x22_r;
  logic signed [23:0]  level_r;
  logic [6:0]          k_r;
  logic [15:0]         fr_r;
  logic signed [14:0]  res_r;
  logic                out_valid_r;
  logic signed [14:0]  out_sample_r;
  logic [14:0]         rom_q_r;
  logic                rom_spec_r;
  logic                rom_neg_r;

  logic [SIZE_W-1:0]   size_eff;
  logic [15:0]         si17;
  logic [21:0]         cand;
  logic                ge;
  logic [16:0]         r_fin;
  logic [SIZE_W-1:0]   ra;
  logic [STORE_AW-1:0] rd_addr;
  logic signed [8:0]   c0, c1, c2, c3;
  logic signed [10:0]  l_v, m_v, h_v;
  logic [31:0]         ph_sel;
  logic [SINE_AW-1:0]  rom_p;
  logic [SINE_AW-1:0]  rom_addr;
  logic [15:0]         sv_mag;
  logic signed [16:0]  sv;
  logic [16:0]         al;
  logic signed [49:0]  x_sum;
  logic signed [49:0]  lv_sum;
  logic signed [33:0]  lv_sh;
  logic signed [23:0]  lv_sat;
  logic signed [24:0]  lvl_ext;
  logic [24:0]         mag;
  logic [5:0]          tk;
  logic [13:0]         tdiff;
  logic [31:0]         rnd;
  logic [13:0]         y_val;
  logic                mem_we;

  always_comb begin
    if (mem_size_r < SIZE_W'(SIZE_MIN)) size_eff = SIZE_W'(SIZE_MIN);
    else if (mem_size_r > SIZE_W'(STORE_DEPTH)) size_eff = SIZE_W'(STORE_DEPTH);
    else size_eff = mem_size_r;
  end

  assign cfg_ready = (state_r == S_IDLE) && !fetch.valid;
  assign fetch_pop = (state_r == S_IDLE) && fetch.valid;
  assign mem_we    = fetch_pop && (fetch.cmd.op == OP_WRITE);
  assign out_empty  = !out_valid_r;
  assign out_sample = out_sample_r;

  assign si17 = 16'({fetch.cmd.sample_index, 4'b0000} + 20'(fetch.cmd.sample_index));

  // restoring reduction, one quotient bit per cycle
  assign cand  = 22'(size_eff) << mod_j_r;
  assign ge    = 22'(mod_r) >= cand;
  assign r_fin = ge ? (mod_r - cand[16:0]) : mod_r;

  always_comb begin
    ra = SIZE_W'(idx_r) + SIZE_W'(rd_cnt_r[1:0]);
    if (ra >= size_eff) ra = ra - size_eff;
    rd_addr = ra[STORE_AW-1:0];
  end

  always_ff @(posedge clk) begin
    if (mem_we) store_mem[fetch.cmd.address] <= fetch.cmd.data;
    mem_q_r <= store_mem[rd_addr];
  end

  always_comb begin
    c0  = $signed({1'b0, b_r[0]}) - 9'sd128;
    c1  = $signed({1'b0, b_r[1]}) - 9'sd128;
    c2  = $signed({1'b0, b_r[2]}) - 9'sd128;
    c3  = $signed({1'b0, b_r[3]}) - 9'sd128;
    l_v = 11'(c0) + 11'(c1) + 11'(c2) + 11'(c3);
    m_v = 11'(c0) + 11'(c1) - 11'(c2) - 11'(c3);
    h_v = 11'(c0) - 11'(c1) - 11'(c2) + 11'(c3);
  end

  // sine lookup with quadrant folding
  always_comb begin
    case (step_r)
      5'd17:   ph_sel = pm_r;
      5'd18:   ph_sel = ph_r;
      default: ph_sel = phase_low_r;
    endcase
    rom_p    = ph_sel[31-2 -: SINE_AW];
    rom_addr = ph_sel[30] ? (~rom_p + 1'b1) : rom_p;
  end

  always_ff @(posedge clk) begin
    rom_q_r    <= SINE_ROM[rom_addr];
    rom_spec_r <= ph_sel[30] && (rom_p == '0);
    rom_neg_r  <= ph_sel[31];
  end

  assign sv_mag = rom_spec_r ? 16'd32767 : {1'b0, rom_q_r};
  assign sv     = rom_neg_r ? -$signed(17'(sv_mag)) : $signed(17'(sv_mag));

  assign al      = 17'd32768 + {1'b0, abs_l_r, 6'b000000};
  assign lvl_ext = 25'(level_r);
  assign mag     = lvl_ext[24] ? 25'(-lvl_ext) : 25'(lvl_ext);
  assign tk      = (k_r < 7'd33) ? k_r[5:0] : 6'd0;
  assign tdiff   = TANH_TAB[tk + 6'd1] - TANH_TAB[tk];
  assign rnd     = (prod_r[31:0] + 32'd32768) >> 16;
  assign y_val   = (k_r >= 7'd33) ? 14'd15000 : (TANH_TAB[tk] + rnd[13:0]);

  assign x_sum  = acc_r + 50'(prod_r) + 50'sd16777216;
  assign lv_sum = acc_r + 50'(prod_r) + 50'sd32768;
  assign lv_sh  = 34'(lv_sum >>> 16);

  always_comb begin
    if (lv_sh > 34'sd8388607) lv_sat = 24'sd8388607;
    else if (lv_sh < -34'sd8388608) lv_sat = -24'sd8388608;
    else lv_sat = 24'(lv_sh);
  end

  always_comb begin
    case (step_r)
      5'd0:    begin mul_a = 33'sd200;   mul_b = 33'(mm_r);          end
      5'd1:    begin mul_a = 33'sd1200;  mul_b = 33'(mm_r);          end
      5'd2:    begin mul_a = 33'sd2200;  mul_b = 33'(mm_r);          end
      5'd3:    begin mul_a = 33'(l_r) + 33'sd512;     mul_b = 33'(fl_k_r); end
      5'd4:    begin mul_a = 33'(abs_m_r) + 33'sd256; mul_b = 33'(fm_k_r); end
      5'd5:    begin mul_a = 33'(abs_h_r) + 33'sd256; mul_b = 33'(fh_k_r); end
      5'd6:    begin mul_a = 33'(fl_r);  mul_b = 33'(step_hz_r);     end
      5'd7:    begin mul_a = 33'(fm_r);  mul_b = 33'(step_hz_r);     end
      5'd8:    begin mul_a = 33'(fh_r);  mul_b = 33'(step_hz_r);     end
      5'd9:    begin mul_a = 33'(l_r);   mul_b = 33'sd1602106;       end
      5'd10:   begin mul_a = 33'(m_r);   mul_b = 33'sd4539301;       end
      5'd11:   begin mul_a = 33'sd45875; mul_b = 33'(abs_m_r);       end
      5'd12:   begin mul_a = 33'sd52429; mul_b = 33'(abs_h_r);       end
      5'd13:   begin mul_a = 33'sd36045; mul_b = 33'(al);            end
      5'd14:   begin mul_a = 33'sd19661; mul_b = 33'(am_r);          end
      5'd15:   begin mul_a = 33'sd9830;  mul_b = 33'(ah_r);          end
      5'd18:   begin mul_a = 33'(cl_r);  mul_b = 33'(sl_r);          end
      5'd19:   begin mul_a = 33'(cm_r);  mul_b = 33'(sm_r);          end
      5'd20:   begin mul_a = 33'(ch_r);  mul_b = 33'(sh_r);          end
      5'd21:   begin mul_a = 33'sd64553; mul_b = 33'(level_r);       end
      5'd22:   begin mul_a = 33'sd983;   mul_b = 33'(x22_r);         end
      5'd24:   begin mul_a = 33'({mag[23:0], 1'b0}); mul_b = 33'hCCCCCCCD; end
      5'd26:   begin mul_a = 33'(tdiff); mul_b = 33'(fr_r);          end
      default: begin mul_a = '0;         mul_b = '0;                 end
    endcase
  end

  always_ff @(posedge clk) begin
    prod_r <= mul_a * mul_b;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      out_valid_r  <= 1'b0;
      mem_size_r   <= SIZE_W'(STORE_DEPTH);
      step_hz_r    <= 28'd22906492;
      jump_r       <= 8'd17;
      rp_r         <= '0;
      phase_low_r  <= '0;
      phase_mid_r  <= '0;
      phase_high_r <= '0;
      level_r      <= '0;
      step_r       <= '0;
      rd_cnt_r     <= '0;
      mod_j_r      <= '0;
      mod_for_r    <= MOD_INDEX;
    end else begin
      if (out_pop && out_valid_r && (state_r != S_OUT)) out_valid_r <= 1'b0;
      case (state_r)
        S_IDLE: begin
          if (cfg_valid && cfg_ready) begin
            case (cfg_idx_t'(cfg_index))
              CFG_MEM_SIZE: begin
                mem_size_r <= cfg_data[SIZE_W-1:0];
                mod_r      <= 17'(rp_r);
                mod_j_r    <= 4'd9;
                mod_for_r  <= MOD_POINTER;
                state_r    <= S_MOD;
              end
              CFG_STEP_PER_HZ:  step_hz_r <= cfg_data;
              CFG_POINTER_JUMP: jump_r <= cfg_data[7:0];
              CFG_START_OFFSET: begin
                mod_r     <= 17'(cfg_data[STORE_AW-1:0]);
                mod_j_r   <= 4'd9;
                mod_for_r <= MOD_POINTER;
                state_r   <= S_MOD;
              end
              default: ;
            endcase
          end else if (fetch_pop && fetch.cmd.op == OP_SAMPLE) begin
            si_r      <= fetch.cmd.sample_index;
            mm_r      <= fetch.cmd.macro_mod;
            mod_r     <= 17'(rp_r) + 17'(si17);
            mod_j_r   <= 4'd9;
            mod_for_r <= MOD_INDEX;
            state_r   <= S_MOD;
          end
        end
        S_MOD: begin
          mod_r   <= r_fin;
          mod_j_r <= mod_j_r - 4'd1;
          if (mod_j_r == 4'd0) begin
            if (mod_for_r == MOD_INDEX) begin
              idx_r    <= r_fin[STORE_AW-1:0];
              rd_cnt_r <= '0;
              state_r  <= S_RD;
            end else begin
              rp_r    <= r_fin[STORE_AW-1:0];
              state_r <= S_IDLE;
            end
          end
        end
        S_RD: begin
          if (rd_cnt_r != 3'd0) b_r[2'(rd_cnt_r - 3'd1)] <= mem_q_r;
          rd_cnt_r <= rd_cnt_r + 3'd1;
          if (rd_cnt_r == 3'd4) state_r <= S_BAND;
        end
        S_BAND: begin
          l_r     <= l_v;
          m_r     <= m_v;
          abs_l_r <= l_v[10] ? 10'(-l_v) : l_v[9:0];
          abs_m_r <= m_v[10] ? 10'(-m_v) : m_v[9:0];
          abs_h_r <= h_v[10] ? 10'(-h_v) : h_v[9:0];
          step_r  <= '0;
          state_r <= S_CALC;
        end
        S_CALC: begin
          step_r <= step_r + 5'd1;
          case (step_r)
            5'd1:  fl_k_r <= 25'd9175040 + prod_r[24:0];
            5'd2:  fm_k_r <= 28'd58982400 + prod_r[27:0];
            5'd3:  fh_k_r <= 29'd209715200 + prod_r[28:0];
            5'd4:  fl_r <= 25'd2621440 + prod_r[34:10];
            5'd5:  fm_r <= 28'd9175040 + prod_r[36:9];
            5'd6:  fh_r <= 30'd45875200 + prod_r[38:9];
            5'd7:  phase_low_r <= phase_low_r + prod_r[55:24];
            5'd8:  phase_mid_r <= phase_mid_r + prod_r[55:24];
            5'd9:  phase_high_r <= phase_high_r + prod_r[55:24];
            5'd10: pm_r <= phase_mid_r + prod_r[31:0];
            5'd11: ph_r <= phase_high_r + prod_r[31:0];
            5'd12: am_r <= 17'd19661 + 17'(prod_r[24:8]);
            5'd13: ah_r <= 17'd13107 + 17'(prod_r[24:8]);
            5'd14: cl_r <= prod_r[31:0];
            5'd15: cm_r <= prod_r[31:0];
            5'd16: ch_r <= prod_r[31:0];
            5'd17: sl_r <= sv;
            5'd18: sm_r <= sv;
            5'd19: begin
              sh_r  <= sv;
              acc_r <= 50'(prod_r);
            end
            5'd20: acc_r <= acc_r + 50'(prod_r);
            5'd21: x22_r <= 24'(x_sum >>> 25);
            5'd22: acc_r <= 50'(prod_r);
            5'd23: level_r <= lv_sat;
            5'd25: begin
              k_r  <= prod_r[56:50];
              fr_r <= prod_r[49:34];
            end
            5'd27: begin
              res_r   <= level_r[23] ? -$signed(15'(y_val)) : $signed(15'(y_val));
              state_r <= S_OUT;
            end
            default: ;
          endcase
        end
        S_OUT: begin
          if (!out_valid_r || out_pop) begin
            out_valid_r  <= 1'b1;
            out_sample_r <= res_r;
            if (si_r[11:0] == 12'd0) begin
              mod_r     <= 17'(rp_r) + 17'd1 + 17'(b_r[0]) + 17'(jump_r);
              mod_j_r   <= 4'd9;
              mod_for_r <= MOD_POINTER;
              state_r   <= S_MOD;
            end else begin
              state_r <= S_IDLE;
            end
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ===== rtl/core/memory_wavelet_oscillator_voice.sv =====
// ----------------------------------------------------------------------------
// memory_wavelet_oscillator_voice
// Byte store voice: writes fill the store, sample requests make one sample.
// ----------------------------------------------------------------------------
// flow: a sample request leaves the queue, then runs reduction, store reads,
//   band split and calculation; the back ends one sample before it takes the next
// throughput: store writes retire one per cycle while the back is idle; a sample
//   whose low 12 bits of sample_index are zero adds a pointer reduction
// reset: clears queue, result slot, pointer, phases, level; config gets defaults;
//   store contents stay undefined; size/offset writes busy cfg in pointer reduction
module memory_wavelet_oscillator_voice import mwo_pkg::*; (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_push,
  output logic                in_full,
  input  logic                in_op,
  input  logic [STORE_AW-1:0] in_address,
  input  logic [7:0]          in_data,
  input  logic [15:0]         in_sample_index,
  input  logic [15:0]         in_macro_mod,
  output logic                out_empty,
  input  logic                out_pop,
  output logic signed [14:0]  out_sample,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [27:0]         cfg_data
);

  fetch_t fetch;
  logic   fetch_pop;

  mwo_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_op           (in_op),
    .in_address      (in_address),
    .in_data         (in_data),
    .in_sample_index (in_sample_index),
    .in_macro_mod    (in_macro_mod),
    .fetch           (fetch),
    .fetch_pop       (fetch_pop)
  );

  mwo_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .fetch      (fetch),
    .fetch_pop  (fetch_pop),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .out_empty  (out_empty),
    .out_pop    (out_pop),
    .out_sample (out_sample)
  );

endmodule

// ===== rtl/core/mwo_check.sv =====
// ----------------------------------------------------------------------------
// mwo_check
// Port-level checks of the wavelet oscillator voice.
// ----------------------------------------------------------------------------
module mwo_check import mwo_pkg::*; (
  input logic                clk,
  input logic                rst_n,
  input logic                in_full,
  input logic                out_empty,
  input logic                out_pop,
  input logic signed [14:0]  out_sample,
  input logic                cfg_valid,
  input logic                cfg_ready,
  input logic [1:0]          cfg_index
);

  // result waits unchanged until taken
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty && !out_pop |=> !out_empty && $stable(out_sample))
    else $error("result changed while waiting");

  a_out_range: assert property (@(posedge clk) disable iff (!rst_n)
    !out_empty |-> (out_sample <= 15'sd15000) && (out_sample >= -15'sd15000))
    else $error("sample out of range");

  a_reset_state: assert property (@(posedge clk)
    !rst_n |=> out_empty && !in_full)
    else $error("queues not empty after reset");

  // size and offset writes start a pointer reduction
  a_cfg_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_valid && cfg_ready &&
    (cfg_index == CFG_MEM_SIZE || cfg_index == CFG_START_OFFSET) |=> !cfg_ready)
    else $error("cfg ready during pointer reduction");

endmodule

bind memory_wavelet_oscillator_voice mwo_check u_mwo_check (.*);
